>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam int SCROLL_END = (ROWS - 1) * COLUMNS;
    localparam int FILL_START = (ROWS - 2) * COLUMNS;

    localparam int TAB_STOP = 7;
    localparam int MOD_W    = $clog2(TAB_STOP);

    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int IN_ADDR_W  = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int CELL_W     = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKGROUND = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'h7;
    localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'h0;
    localparam logic [CELL_W-1:0]     INIT_CELL = {BG_RESET, FG_RESET, CH_SPACE};

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EXEC,
        OP_SCROLL,
        OP_FILL,
        OP_CLEAR,
        OP_INIT
    } op_t;

    typedef enum logic [1:0] {
        NEXT_DONE,
        NEXT_SCROLL,
        NEXT_CLEAR
    } exec_next_t;

    typedef struct packed {
        op_t  mode;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        exec_next_t exec_next;
        logic       sweep_done;
    } dp_sts_t;

endpackage

>>> design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset clearing pass, item execution, scroll, fill and clear
// sweeps, and the result handshake.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tcw_pkg::dp_sts_t  sts,
    output tcw_pkg::ctl_cmd_t cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.mode     = OP_NONE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.mode = OP_INIT;
                if (sts.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.mode   = OP_ACCEPT;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.mode = OP_EXEC;
                unique case (sts.exec_next)
                    NEXT_SCROLL: state_next = ST_SCROLL;
                    NEXT_CLEAR:  state_next = ST_CLEAR;
                    default: begin
                        if (out_free) begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_SCROLL: begin
                cmd.mode = OP_SCROLL;
                if (sts.sweep_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.mode = OP_FILL;
                if (sts.sweep_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                cmd.mode = OP_CLEAR;
                if (sts.sweep_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("Result loaded while the output register is still occupied.");

    a_scroll_then_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && sts.sweep_done) |=> state_reg == ST_FILL)
        else $error("Scroll sweep did not hand over to the row fill.");
`endif

endmodule

>>> design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen store, cursor and colour registers, sweep counter and result
// register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [tcw_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  tcw_pkg::ctl_cmd_t                    cmd,
    output tcw_pkg::dp_sts_t                     sts,
    output logic [tcw_pkg::M_TDATA_W-1:0]        m_tdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [ACTION_W-1:0]   act_reg;
    logic [CHAR_W-1:0]     ch_reg;
    logic [IN_ADDR_W-1:0]  addr_reg;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [MOD_W-1:0]      mod_reg, mod_next;
    logic [CFG_DATA_W-1:0] fg_reg, bg_reg;
    logic [ADDR_W-1:0]     sweep_reg, sweep_next;
    logic                  copy_pend_reg;
    logic [ADDR_W-1:0]     copy_addr_reg;
    logic [CELL_W-1:0]     rd_data_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [ACTION_W-1:0]   in_action;
    logic [CHAR_W-1:0]     in_char;
    logic [IN_ADDR_W-1:0]  in_addr;

    exec_next_t            exec_next;
    logic                  sweep_done;
    logic                  put_wr;
    logic                  new_line;
    logic [COL_W:0]        tab_sum;
    logic [ADDR_W-1:0]     cursor_addr;
    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [CELL_W-1:0]     wr_data;
    logic [CELL_W-1:0]     cell_out;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_char   = s_tdata[ACTION_W+CHAR_W-1:ACTION_W];
    assign in_addr   = s_tdata[ACTION_W+CHAR_W+IN_ADDR_W-1:ACTION_W+CHAR_W];

    assign sts = '{exec_next: exec_next, sweep_done: sweep_done};

    assign tab_sum     = (COL_W+1)'(col_reg) + (COL_W+1)'(TAB_STOP) - (COL_W+1)'(mod_reg);
    assign cursor_addr = ADDR_W'(int'(row_reg) * COLUMNS) + ADDR_W'(col_reg);

    // Cursor update for the item held in the item registers.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        mod_next   = mod_reg;
        put_wr     = 1'b0;
        new_line   = 1'b0;
        exec_next  = NEXT_DONE;
        if (cmd.mode == OP_EXEC) begin
            if (act_reg == ACT_CLEAR) begin
                col_next  = '0;
                row_next  = '0;
                mod_next  = '0;
                exec_next = NEXT_CLEAR;
            end else if (act_reg == ACT_PUT) begin
                unique case (ch_reg)
                    CH_BACKSPACE: begin
                        if (col_reg != '0) begin
                            col_next = col_reg - 1'b1;
                            mod_next = (mod_reg == '0) ? MOD_W'(TAB_STOP - 1)
                                                       : mod_reg - 1'b1;
                        end
                    end
                    CH_TAB: begin
                        mod_next = '0;
                        if (tab_sum >= (COL_W+1)'(COLUMNS)) begin
                            col_next = '0;
                            new_line = 1'b1;
                        end else begin
                            col_next = tab_sum[COL_W-1:0];
                        end
                    end
                    CH_LINEFEED: begin
                        col_next = '0;
                        mod_next = '0;
                        new_line = 1'b1;
                    end
                    CH_RETURN: begin
                        col_next = '0;
                        mod_next = '0;
                    end
                    default: begin
                        put_wr = 1'b1;
                        if (col_reg == COL_W'(COLUMNS - 1)) begin
                            col_next = '0;
                            mod_next = '0;
                            new_line = 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                            mod_next = (mod_reg == MOD_W'(TAB_STOP - 1)) ? '0
                                                                         : mod_reg + 1'b1;
                        end
                    end
                endcase
                if (new_line) begin
                    if (row_reg == ROW_W'(ROWS - 2)) begin
                        exec_next = NEXT_SCROLL;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        sweep_done = 1'b0;
        case (cmd.mode)
            OP_INIT, OP_CLEAR: sweep_done = (sweep_reg == ADDR_W'(CELL_COUNT - 1));
            OP_SCROLL:         sweep_done = (sweep_reg == ADDR_W'(SCROLL_END));
            OP_FILL:           sweep_done = (sweep_reg == ADDR_W'(SCROLL_END - 1));
            default:           sweep_done = 1'b0;
        endcase
    end

    // Memory port selection.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = INIT_CELL;
        rd_en   = 1'b0;
        rd_addr = sweep_reg;
        case (cmd.mode)
            OP_INIT: begin
                wr_en = 1'b1;
            end
            OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = {bg_reg, fg_reg, CH_SPACE};
            end
            OP_FILL: begin
                wr_en   = 1'b1;
                wr_data = {4'h0, fg_reg, 8'h00};
            end
            OP_SCROLL: begin
                wr_en   = copy_pend_reg;
                wr_addr = copy_addr_reg - ADDR_W'(COLUMNS);
                wr_data = rd_data_reg;
                rd_en   = (sweep_reg < ADDR_W'(SCROLL_END));
            end
            OP_EXEC: begin
                wr_en   = put_wr;
                wr_addr = cursor_addr;
                wr_data = {bg_reg, fg_reg, ch_reg};
            end
            OP_ACCEPT: begin
                rd_en   = (in_action == ACT_READ) && (int'(in_addr) < CELL_COUNT);
                rd_addr = ADDR_W'(in_addr);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        sweep_next = sweep_reg;
        case (cmd.mode)
            OP_EXEC: begin
                sweep_next = (exec_next == NEXT_SCROLL) ? ADDR_W'(COLUMNS) : '0;
            end
            OP_SCROLL: begin
                sweep_next = sweep_done ? ADDR_W'(FILL_START) : sweep_reg + 1'b1;
            end
            OP_INIT, OP_CLEAR, OP_FILL: begin
                sweep_next = sweep_done ? '0 : sweep_reg + 1'b1;
            end
            default: sweep_next = sweep_reg;
        endcase
    end

    assign cell_out = ((act_reg == ACT_READ) && (int'(addr_reg) < CELL_COUNT))
                      ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            mod_reg       <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= (cmd.mode == OP_EXEC && exec_next == NEXT_SCROLL)
                             ? ROW_W'(ROWS - 2) : row_next;
            mod_reg       <= mod_next;
            sweep_reg     <= sweep_next;
            copy_pend_reg <= (cmd.mode == OP_SCROLL) && rd_en;
            if (cfg_wr_en) begin
                if (cfg_addr == REG_FOREGROUND) begin
                    fg_reg <= cfg_wdata;
                end else begin
                    bg_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= sweep_reg;
        if (cmd.mode == OP_ACCEPT) begin
            act_reg  <= in_action;
            ch_reg   <= in_char;
            addr_reg <= in_addr;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= M_TDATA_W'({cell_out, OUT_ROW_W'(row_next), OUT_COL_W'(col_next)});
        end
    end

    assign m_tdata = m_tdata_reg;

`ifndef ASSERT_OFF
    a_write_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> int'(wr_addr) < CELL_COUNT)
        else $error("Screen store written outside its cells.");

    a_cursor_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(row_reg) <= ROWS - 2) && (int'(col_reg) < COLUMNS)
        && (int'(mod_reg) < TAB_STOP))
        else $error("Cursor left the text area.");

    a_fill_on_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mode == OP_FILL) |-> row_reg == ROW_W'(ROWS - 2))
        else $error("Row fill running while the cursor is not on the last text row.");
`endif

endmodule

>>> design/text_console_writer_top.sv
// Put character, read cell and unused action: result loaded in the execute or done state.
// A new line off the last text row adds a scroll sweep and a fill of the last text row.
// Clear: sweeps all CELL_COUNT cells, one store write per cycle on the single write port.
// One item at a time; the next is taken once the result is in the output register.
// After reset a clearing pass writes all CELL_COUNT cells with s_tready low.
// ----------------------------------------------------------------------------
// Text console writer top level
// Character-cell console engine with a streaming item and result channel.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // action [1:0], char_code [9:2], cell_address [20:10], zero fill [23:21]
    input  logic [tcw_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cursor_column [6:0], cursor_row [11:7], cell_value [27:12], zero fill [31:28]
    output logic [tcw_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tcw_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

>>> sim/text_console_writer_top_tb.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put-character, clear, read and unused-action transactions with random
// flow control on both channels, mirrors the screen store, cursor and colours
// in a scoreboard, and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned ITEMS_PER_SEGMENT = 230;

    typedef struct packed {
        logic [2:0]           pad;
        logic [IN_ADDR_W-1:0] cell_address;
        logic [CHAR_W-1:0]    char_code;
        logic [ACTION_W-1:0]  action;
    } console_item_t;

    typedef struct packed {
        logic [3:0]           pad;
        logic [CELL_W-1:0]    cell_value;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_column;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        int unsigned       column;
        int unsigned       row;
        logic [3:0]        fg;
        logic [3:0]        bg;
        console_result_t   pending_results [$];
        int unsigned       errors;

        function new();
            foreach (cells[i]) cells[i] = {BG_RESET, FG_RESET, CH_SPACE};
            column = 0;
            row    = 0;
            fg     = FG_RESET;
            bg     = BG_RESET;
            errors = 0;
        endfunction

        function void report_failure(string what);
            errors++;
            if (errors <= 10) begin
                $display("%0t ns: %s", $time, what);
            end
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] index, logic [3:0] value);
            if (index == REG_FOREGROUND) begin
                fg = value;
            end else begin
                bg = value;
            end
        endfunction

        // Advances the row; off the last text row, rows 1 to ROWS-2 move up by one and the last text row is blanked.
        function void take_new_line();
            row++;
            if (row >= ROWS - 1) begin
                for (int i = 0; i < (ROWS - 2) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                for (int c = 0; c < COLUMNS; c++) cells[(ROWS - 2) * COLUMNS + c] = {4'h0, fg, 8'h00};
                row = ROWS - 2;
            end
        endfunction

        function void accept_item(console_item_t item);
            console_result_t want;
            int unsigned     pos;
            want = '0;
            case (item.action)
                ACT_PUT: begin
                    case (item.char_code)
                        CH_BACKSPACE: begin
                            if (column > 0) column--;
                        end
                        CH_TAB: begin
                            column += TAB_STOP - (column % TAB_STOP);
                            if (column >= COLUMNS) begin
                                column = 0;
                                take_new_line();
                            end
                        end
                        CH_LINEFEED: begin
                            take_new_line();
                            column = 0;
                        end
                        CH_RETURN: begin
                            column = 0;
                        end
                        default: begin
                            pos = row * COLUMNS + column;
                            if (pos < CELL_COUNT) cells[pos] = {bg, fg, item.char_code};
                            column++;
                            if (column >= COLUMNS) begin
                                column = 0;
                                take_new_line();
                            end
                        end
                    endcase
                end
                ACT_CLEAR: begin
                    foreach (cells[i]) cells[i] = {bg, fg, CH_SPACE};
                    column = 0;
                    row    = 0;
                end
                ACT_READ: begin
                    if (item.cell_address < CELL_COUNT) want.cell_value = cells[item.cell_address];
                end
                default: begin
                end
            endcase
            want.cursor_column = column[OUT_COL_W-1:0];
            want.cursor_row    = row[OUT_ROW_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result transaction %h with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row ||
                got.cell_value !== want.cell_value || got.pad !== want.pad) begin
                report_failure($sformatf({"result mismatch: column exp %0d got %0d, ",
                    "row exp %0d got %0d, value exp %h got %h, fill exp %h got %h"},
                    want.cursor_column, got.cursor_column, want.cursor_row, got.cursor_row,
                    want.cell_value, got.cell_value, want.pad, got.pad));
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    int unsigned       items_sent;
    console_scoreboard console_check;

    text_console_writer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) console_check.check_result(m_tdata);
    end

    initial begin
        #600_000_000;
        $display("[text_console_writer_top] ERROR");
        $finish;
    end

    task automatic send_item(input logic [ACTION_W-1:0] action, input logic [CHAR_W-1:0] ch,
                             input logic [IN_ADDR_W-1:0] addr);
        console_item_t item;
        item = '{pad: '0, cell_address: addr, char_code: ch, action: action};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        console_check.accept_item(item);
        if (action != ACT_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (console_check.pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_colours(input logic [3:0] fg, input logic [3:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_FOREGROUND;
        cfg_wdata <= fg;
        @(negedge aclk);
        cfg_addr  <= REG_BACKGROUND;
        cfg_wdata <= bg;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        console_check.set_register(REG_FOREGROUND, fg);
        console_check.set_register(REG_BACKGROUND, bg);
        @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(7) == 0) return CHAR_W'($urandom_range(255));
        return CHAR_W'($urandom_range(126, 32));
    endfunction

    // Reads favour the cell behind the cursor, the scrolled text row and the reserved row.
    function automatic logic [IN_ADDR_W-1:0] pick_read_address();
        int unsigned pos;
        pos = console_check.row * COLUMNS + console_check.column;
        case ($urandom_range(4))
            0: return (pos > 0) ? IN_ADDR_W'(pos - 1) : '0;
            1: return IN_ADDR_W'((ROWS - 2) * COLUMNS + $urandom_range(COLUMNS - 1));
            2: return IN_ADDR_W'((ROWS - 1) * COLUMNS + $urandom_range(COLUMNS - 1));
            3: return IN_ADDR_W'($urandom_range(CELL_COUNT - 1));
            default: return IN_ADDR_W'($urandom_range(2 ** IN_ADDR_W - 1, CELL_COUNT));
        endcase
    endfunction

    function automatic logic [IN_ADDR_W-1:0] pick_any_address();
        return IN_ADDR_W'($urandom_range(2 ** IN_ADDR_W - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_any_char();
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic run_sequence();
        int unsigned kind;
        int unsigned count;
        kind = $urandom_range(99);
        if (kind < 40) begin
            count = $urandom_range(90, 1);
            repeat (count) send_item(ACT_PUT, pick_char(), pick_any_address());
        end else if (kind < 52) begin
            count = $urandom_range(26, 1);
            repeat (count) send_item(ACT_PUT, CH_LINEFEED, pick_any_address());
        end else if (kind < 60) begin
            count = $urandom_range(13, 1);
            repeat (count) send_item(ACT_PUT, CH_TAB, pick_any_address());
        end else if (kind < 68) begin
            count = $urandom_range(4, 1);
            repeat (count) begin
                send_item(ACT_PUT, ($urandom_range(1) != 0) ? CH_BACKSPACE : CH_RETURN,
                          pick_any_address());
            end
        end else if (kind < 88) begin
            count = $urandom_range(6, 1);
            repeat (count) send_item(ACT_READ, pick_any_char(), pick_read_address());
        end else if (kind < 91) begin
            send_item(ACT_CLEAR, pick_any_char(), pick_any_address());
        end else if (kind < 95) begin
            send_item(ACT_UNUSED, pick_any_char(), pick_any_address());
        end else begin
            count = $urandom_range(3, 1);
            repeat (count) begin
                send_item(ACTION_W'($urandom_range(3)), pick_any_char(), pick_any_address());
            end
        end
    endtask

    initial begin
        int unsigned target;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        items_sent  = 0;
        console_check = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        send_item(ACT_READ, 8'h00, 11'd0);
        send_item(ACT_READ, 8'h00, IN_ADDR_W'(CELL_COUNT - 1));
        send_item(ACT_READ, 8'h00, IN_ADDR_W'(CELL_COUNT));
        send_item(ACT_READ, 8'hFF, 11'h7FF);
        send_item(ACT_PUT, 8'hFF, 11'd0);
        send_item(ACT_PUT, 8'h00, 11'd0);
        send_item(ACT_PUT, 8'h41, 11'd0);
        send_item(ACT_PUT, CH_BACKSPACE, 11'd0);
        send_item(ACT_PUT, CH_RETURN, 11'd0);
        send_item(ACT_PUT, CH_BACKSPACE, 11'd0);
        send_item(ACT_PUT, CH_TAB, 11'd0);
        send_item(ACT_PUT, CH_TAB, 11'd0);
        send_item(ACT_PUT, CH_LINEFEED, 11'd0);
        send_item(ACT_PUT, 8'h7E, 11'd0);
        send_item(ACT_UNUSED, 8'hFF, 11'h7FF);
        send_item(ACT_READ, 8'h00, IN_ADDR_W'(COLUMNS));
        send_item(ACT_READ, 8'h00, 11'd0);
        send_item(ACT_READ, 8'h00, 11'd1);
        send_item(ACT_CLEAR, 8'h00, 11'd0);
        send_item(ACT_READ, 8'h00, IN_ADDR_W'(CELL_COUNT - 1));
        send_item(ACT_READ, 8'h00, 11'd0);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                tx_idle_pct = 30;
                rx_idle_pct = 88;
            end else if (seg < 4) begin
                tx_idle_pct = 88;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg > 0) begin
                wait_idle();
                case (seg)
                    1: write_colours(4'hF, 4'hF);
                    2: write_colours(4'h0, 4'h0);
                    3: write_colours(4'hF, 4'h0);
                    4: write_colours(4'h0, 4'hF);
                    default: write_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
                endcase
            end
            target = items_sent + ITEMS_PER_SEGMENT;
            while (items_sent < target) run_sequence();
        end

        wait_idle();
        if (console_check.pending_results.size() != 0) begin
            console_check.report_failure("result transactions missing at the end of the run");
        end
        if (console_check.errors == 0) begin
            $display("[text_console_writer_top] OK");
        end else begin
            $display("[text_console_writer_top] ERROR");
        end
        $finish;
    end

endmodule
